FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk while rst_n is high.
`define MHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen while rst_n is high.
`define MHD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `MHD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: src/mhd_pkg.sv
// Shared types and constants of the message header deframer.
package mhd_pkg;

    localparam int unsigned LEN_W     = 32;
    localparam int unsigned ID_W      = 32;
    localparam int unsigned MAGIC_W   = 16;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned TUSER_W   = 5;
    localparam int unsigned APB_AW    = 4;
    localparam int unsigned APB_DW    = 32;

    localparam logic [LEN_W-1:0] HEADER_BYTES = 32'd10;
    localparam logic [CNT_W-1:0] MAGIC_END    = 4'd2;
    localparam logic [CNT_W-1:0] LENGTH_END   = 4'd6;
    localparam logic [CNT_W-1:0] LAST_HDR_IDX = 4'd9;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN_ID = 2'd2;
    localparam logic [1:0] ST_SHORT_LEN  = 2'd3;

    localparam logic [1:0] KIND_LOGIN = 2'd0;
    localparam logic [1:0] KIND_VIDEO = 2'd1;
    localparam logic [1:0] KIND_AUDIO = 2'd2;

    localparam logic [1:0] REG_MAGIC = 2'd0;
    localparam logic [1:0] REG_LOGIN = 2'd1;
    localparam logic [1:0] REG_VIDEO = 2'd2;
    localparam logic [1:0] REG_AUDIO = 2'd3;

    typedef struct packed {
        logic [MAGIC_W-1:0] magic_value;
        logic [ID_W-1:0]    login_id;
        logic [ID_W-1:0]    video_id;
        logic [ID_W-1:0]    audio_id;
    } t_cfg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] kind;
        logic       last_of_message;
        logic       empty_message;
        logic [1:0] status;
    } t_result;

endpackage

FILE: src/mhd_cfg_regs.sv
// APB register bank holding the expected magic and the three message ids.
module mhd_cfg_regs
    import mhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAGIC: r_cfg.magic_value <= pwdata[MAGIC_W-1:0];
                REG_LOGIN: r_cfg.login_id    <= pwdata;
                REG_VIDEO: r_cfg.video_id    <= pwdata;
                REG_AUDIO: r_cfg.audio_id    <= pwdata;
                default:   r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAGIC: prdata = {{(APB_DW-MAGIC_W){1'b0}}, r_cfg.magic_value};
            REG_LOGIN: prdata = r_cfg.login_id;
            REG_VIDEO: prdata = r_cfg.video_id;
            REG_AUDIO: prdata = r_cfg.audio_id;
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/mhd_parser.sv
// Input register, header collection, checks and payload counting.
module mhd_parser
    import mhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  t_cfg       i_cfg,
    input  logic       i_out_free,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [MAGIC_W-1:0] r_magic,   n_magic;
    logic [LEN_W-1:0]   r_length,  n_length;
    logic [ID_W-1:0]    r_id,      n_id;
    logic [LEN_W-1:0]   r_remain,  n_remain;
    logic [1:0]         r_kind,    n_kind;
    logic               r_halted,  n_halted;
    logic               step;
    logic [LEN_W-1:0]   body_len;

    assign step    = r_in_valid & i_out_free;
    assign o_ready = ~r_in_valid | step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    assign body_len = r_length - HEADER_BYTES;

    always_comb begin
        n_count     = r_count;
        n_magic     = r_magic;
        n_length    = r_length;
        n_id        = r_id;
        n_remain    = r_remain;
        n_kind      = r_kind;
        n_halted    = r_halted;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (step && !r_halted) begin
            if (r_remain != '0) begin
                n_remain              = r_remain - 1'b1;
                o_res_valid           = 1'b1;
                o_res.payload_byte    = r_in_byte;
                o_res.kind            = r_kind;
                o_res.last_of_message = (r_remain == {{(LEN_W-1){1'b0}}, 1'b1});
                o_res.status          = ST_OK;
            end else begin
                if (r_count < MAGIC_END) begin
                    n_magic = {r_magic[MAGIC_W-9:0], r_in_byte};
                end else if (r_count < LENGTH_END) begin
                    n_length = {r_length[LEN_W-9:0], r_in_byte};
                end else begin
                    n_id = {r_id[ID_W-9:0], r_in_byte};
                end

                if (r_count < LAST_HDR_IDX) begin
                    n_count = r_count + 1'b1;
                end else begin
                    // Final header byte: magic and length are complete, the id
                    // is completed by this byte.
                    n_count               = '0;
                    o_res_valid           = 1'b1;
                    o_res.last_of_message = 1'b1;
                    if (r_magic != i_cfg.magic_value) begin
                        n_halted     = 1'b1;
                        o_res.status = ST_BAD_MAGIC;
                    end else if (r_length < HEADER_BYTES) begin
                        n_halted     = 1'b1;
                        o_res.status = ST_SHORT_LEN;
                    end else if (n_id != i_cfg.login_id && n_id != i_cfg.video_id &&
                                 n_id != i_cfg.audio_id) begin
                        n_halted     = 1'b1;
                        o_res.status = ST_UNKNOWN_ID;
                    end else begin
                        if (n_id == i_cfg.login_id) begin
                            n_kind = KIND_LOGIN;
                        end else if (n_id == i_cfg.video_id) begin
                            n_kind = KIND_VIDEO;
                        end else begin
                            n_kind = KIND_AUDIO;
                        end
                        n_remain            = body_len;
                        // A message with payload gives nothing on its header.
                        o_res_valid         = (body_len == '0);
                        o_res.kind          = n_kind;
                        o_res.empty_message = 1'b1;
                        o_res.status        = ST_OK;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_magic  <= '0;
            r_length <= '0;
            r_id     <= '0;
            r_remain <= '0;
            r_kind   <= KIND_LOGIN;
            r_halted <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_magic  <= n_magic;
            r_length <= n_length;
            r_id     <= n_id;
            r_remain <= n_remain;
            r_kind   <= n_kind;
            r_halted <= n_halted;
        end
    end

endmodule

FILE: src/mhd_out_reg.sv
// Result register in front of the master stream interface.
module mhd_out_reg
    import mhd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: src/message_header_deframer.sv
// Top level of the message header deframer.
//
// Usage: the received byte stream enters on the slave stream channel, one byte
// per transaction. Each message starts with a 10-byte big-endian header
// (16-bit magic, 32-bit total length, 32-bit id), followed by length - 10
// payload bytes. Payload bytes leave on the master stream channel with the
// message kind in tuser and tlast on the final byte. A message of length 10
// gives one result flagged empty. Bad magic, a length below 10 or an unknown
// id gives one error result; after that every byte is taken and dropped until
// reset. Registers (magic and three ids) are to be written over the APB
// port only while the stream is idle; the block does not enforce this.
// An accepted byte sits in the input register; its result is loaded into the
// result register when that register is free (not holding a stalled result).
// Throughput: one byte per cycle while the receiver takes results, set by the
// single pass from input register to result register.
// Reset clears the valid flags of both registers, the header counter and the halt flag.
// When the receiver stalls, the result is held, the next byte waits in the
// input register and tready falls until the result is taken.
module message_header_deframer
    import mhd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] data_byte
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // [7:0] payload_byte
    output logic               o_m_axis_tlast,
    output logic [TUSER_W-1:0] o_m_axis_tuser,   // [1:0] kind, [2] empty_message, [4:3] status
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_result step_res;
    t_result out_res;
    logic    step_valid;
    logic    out_free;

    mhd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mhd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_byte      (i_s_axis_tdata),
        .o_ready     (o_s_axis_tready),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    mhd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step_valid),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = out_res.payload_byte;
    assign o_m_axis_tlast = out_res.last_of_message;
    assign o_m_axis_tuser = {out_res.status, out_res.empty_message, out_res.kind};

endmodule

FILE: src/mhd_checker.sv
// Port-level checker for the message header deframer, bound to the top level.
`include "assert_macros.svh"

module mhd_checker
    import mhd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [7:0]         o_m_axis_tdata,
    input logic               o_m_axis_tlast,
    input logic [TUSER_W-1:0] o_m_axis_tuser
);

    logic [1:0]         out_kind;
    logic [1:0]         out_status;
    logic               out_empty;
    logic               out_stall;
    logic [TUSER_W+8:0] out_word;
    logic               empty_bad;
    logic               error_bad;
    logic               kind_bad;

    assign out_kind   = o_m_axis_tuser[1:0];
    assign out_empty  = o_m_axis_tuser[2];
    assign out_status = o_m_axis_tuser[4:3];
    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word   = {o_m_axis_tuser, o_m_axis_tlast, o_m_axis_tdata};

    // An empty message is always the final result of its message and carries no byte.
    assign empty_bad = o_m_axis_tvalid && out_empty &&
                       (!o_m_axis_tlast || o_m_axis_tdata != 8'd0);

    // Error results are final, empty of data and never flagged as empty messages.
    assign error_bad = o_m_axis_tvalid && out_status != ST_OK &&
                       (!o_m_axis_tlast || out_empty || o_m_axis_tdata != 8'd0 ||
                        out_kind != KIND_LOGIN);

    // The kind code never takes the unused value.
    assign kind_bad = o_m_axis_tvalid && out_kind > KIND_AUDIO;

    // A stalled result must be held unchanged.
    `MHD_ASSERT(a_out_hold, i_clk, i_rst_n,
        out_stall |=> o_m_axis_tvalid && $stable(out_word), "stalled result changed")

    `MHD_ASSERT_NEVER(a_empty_last, i_clk, i_rst_n, empty_bad, "malformed empty result")

    `MHD_ASSERT_NEVER(a_error_shape, i_clk, i_rst_n, error_bad, "malformed error result")

    `MHD_ASSERT_NEVER(a_kind_range, i_clk, i_rst_n, kind_bad, "kind out of range")

endmodule

bind message_header_deframer mhd_checker u_mhd_checker (.*);
